>>> rtl/ptc_pkg.sv
package ptc_pkg;

    // coordinate width and the widths that follow from it
    localparam int CW    = 32;
    localparam int DFW   = CW + 1;        // vector difference
    localparam int DOTW  = 2 * DFW + 2;   // dot product of differences
    localparam int PRW   = 2 * DOTW;      // product of two dot products
    localparam int UW    = PRW + 1;       // den, U, V
    localparam int FNW   = UW + DFW + 1;  // projection numerator
    localparam int NW    = FNW + 1;       // divider dividend
    localparam int DW    = UW;            // divider divisor
    localparam int QW    = CW + 2;        // quotient / root bits
    localparam int PW    = CW + 3;        // candidate coordinate
    localparam int D2W   = 2 * PW + 4;    // squared distance
    localparam int RW    = CW + 3;        // root before saturation
    localparam int NLANE = 9;             // divider lanes: one per edge and axis
    localparam int LB    = DOTW / 2;      // multiplier limb
    localparam int NLIMB = 5;             // limbs covering den, U, V

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [DOTW-1:0] dot_t;
    typedef logic signed [PRW-1:0]  prod_t;
    typedef logic signed [UW-1:0]   uv_t;
    typedef logic signed [FNW-1:0]  num_t;
    typedef logic signed [PW-1:0]   cand_t;
    typedef logic signed [D2W-1:0]  dist2_t;

    typedef logic [2:0][CW-1:0]  cvec_t;
    typedef logic [2:0][DFW-1:0] dvec_t;

    // limb operands and their partial products
    typedef logic signed [LB:0]          limb_t;
    typedef logic signed [2*LB+1:0]      pp_t;
    typedef logic [3:0][2*LB+1:0]        pp4_t;
    typedef logic [1:0][2*LB+1:0]        pp2_t;
    typedef logic [NLIMB-1:0][2*LB+1:0]  ppn_t;

    // how an edge candidate is formed
    typedef enum logic [1:0] {PICK_START, PICK_END, PICK_INTERP} pick_t;

    typedef struct packed {
        coord_t query_x;
        coord_t query_y;
        coord_t query_z;
        coord_t corner_a_x;
        coord_t corner_a_y;
        coord_t corner_a_z;
        coord_t corner_b_x;
        coord_t corner_b_y;
        coord_t corner_b_z;
        coord_t corner_c_x;
        coord_t corner_c_y;
        coord_t corner_c_z;
    } query_t;

    typedef struct packed {
        logic [CW:0] distance;
        coord_t      closest_x;
        coord_t      closest_y;
        coord_t      closest_z;
        logic        on_face;
        logic        degenerate;
    } result_t;

    // geometry and decisions that ride alongside the divider
    typedef struct packed {
        cvec_t         q;
        cvec_t [2:0]   p;
        logic          face;
        logic          degen;
        pick_t [2:0]   pick;
    } side_t;

    // chosen point heading into the square root
    typedef struct packed {
        cvec_t pt;
        logic  face;
        logic  degen;
    } hit_t;

    function automatic dvec_t sub3(input cvec_t a, input cvec_t b);
        dvec_t r;
        for (int k = 0; k < 3; k++)
        begin
            r[k] = DFW'($signed(a[k])) - DFW'($signed(b[k]));
        end
        return r;
    endfunction

    function automatic dot_t dot3(input dvec_t a, input dvec_t b);
        dot_t s;
        dot_t x;
        dot_t y;
        s = '0;
        for (int k = 0; k < 3; k++)
        begin
            x = DOTW'($signed(a[k]));
            y = DOTW'($signed(b[k]));
            s = s + x * y;
        end
        return s;
    endfunction

    // one limb product
    function automatic pp_t mul_limb(input limb_t a, input limb_t b);
        pp_t x;
        pp_t y;
        x = pp_t'(a);
        y = pp_t'(b);
        return x * y;
    endfunction

    // dot by dot: low limbs unsigned, high limbs carry the sign
    function automatic pp4_t mulp_parts(input dot_t a, input dot_t b);
        limb_t al;
        limb_t ah;
        limb_t bl;
        limb_t bh;
        pp4_t  r;
        al   = $signed({1'b0, a[LB-1:0]});
        ah   = $signed({a[DOTW-1], a[DOTW-1:LB]});
        bl   = $signed({1'b0, b[LB-1:0]});
        bh   = $signed({b[DOTW-1], b[DOTW-1:LB]});
        r[0] = mul_limb(al, bl);
        r[1] = mul_limb(al, bh);
        r[2] = mul_limb(ah, bl);
        r[3] = mul_limb(ah, bh);
        return r;
    endfunction

    function automatic prod_t mulp_sum(input pp4_t r);
        prod_t s;
        s = prod_t'($signed(r[3])) << (2 * LB);
        s = s + ((prod_t'($signed(r[1])) + prod_t'($signed(r[2]))) << LB);
        s = s + prod_t'($signed(r[0]));
        return s;
    endfunction

    // wide signed word by a coordinate difference
    function automatic ppn_t mulw_parts(input uv_t a, input logic signed [DFW-1:0] b);
        logic signed [NLIMB*LB-1:0] ax;
        limb_t                      bx;
        limb_t                      lm;
        ppn_t                       r;
        ax = (NLIMB*LB)'(a);
        bx = (LB+1)'(b);
        for (int i = 0; i < NLIMB - 1; i++)
        begin
            lm   = $signed({1'b0, ax[i*LB +: LB]});
            r[i] = mul_limb(lm, bx);
        end
        lm         = $signed({ax[NLIMB*LB-1], ax[NLIMB*LB-1 -: LB]});
        r[NLIMB-1] = mul_limb(lm, bx);
        return r;
    endfunction

    function automatic num_t mulw_sum(input ppn_t r);
        num_t s;
        s = '0;
        for (int i = 0; i < NLIMB; i++)
        begin
            s = s + (num_t'($signed(r[i])) << (i * LB));
        end
        return s;
    endfunction

    // dot product by a coordinate difference
    function automatic pp2_t mult_parts(input dot_t a, input logic signed [DFW-1:0] b);
        limb_t al;
        limb_t ah;
        limb_t bx;
        pp2_t  r;
        al   = $signed({1'b0, a[LB-1:0]});
        ah   = $signed({a[DOTW-1], a[DOTW-1:LB]});
        bx   = (LB+1)'(b);
        r[0] = mul_limb(al, bx);
        r[1] = mul_limb(ah, bx);
        return r;
    endfunction

    function automatic num_t mult_sum(input pp2_t r);
        return (num_t'($signed(r[1])) << LB) + num_t'($signed(r[0]));
    endfunction

endpackage

>>> rtl/ptc_front.sv
module ptc_front import ptc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic                          query_valid,
    input  query_t                        query,
    output logic                          lane_valid,
    output side_t                         side,
    output logic [NLANE-1:0][NW-1:0]      numer,
    output logic [NLANE-1:0][DW-1:0]      denom,
    output logic [NLANE-1:0]              negative
);

    logic [8:0] v_reg;

    cvec_t       q_in;
    cvec_t [2:0] p_in;

    cvec_t       q1_reg, q2_reg, q3_reg, q4_reg;
    cvec_t [2:0] p1_reg, p2_reg, p3_reg, p4_reg;
    dvec_t [2:0] e1_reg, e2_reg, e3_reg, e4_reg, e5_reg;
    dvec_t [2:0] w1_reg;

    dot_t  tf2_reg [3];
    dot_t  td2_reg [3];
    dot_t  tf3_reg [3];
    dot_t  td3_reg [3];
    dot_t  tf4_reg [3];
    dot_t  td4_reg [3];
    dot_t  tf5_reg [3];
    dot_t  td5_reg [3];
    dot_t  td6_reg [3];
    dot_t  td7_reg [3];
    dot_t  x01_reg, x02_reg;

    dot_t  d00, d01, d02, d11, d12;
    pp4_t  pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    prod_t ma_reg, mb_reg, mc_reg, md_reg, me_reg, mf_reg;

    prod_t          den;
    uv_t            u_val, v_val;
    logic signed [UW:0] uv_sum, den_x;
    logic           face, degen;
    pick_t [2:0]    pick;
    side_t          side_next;

    prod_t den5_reg, den6_reg, den7_reg;
    uv_t   u5_reg, v5_reg;
    side_t side5_reg, side6_reg, side7_reg;

    ppn_t  fu6_reg [3];
    ppn_t  fv6_reg [3];
    pp2_t  ep6_reg [NLANE];
    num_t  fu7_reg [3];
    num_t  fv7_reg [3];
    num_t  en7_reg [NLANE];

    num_t  lnum [NLANE];
    uv_t   lden [NLANE];

    num_t  num8_reg [NLANE];
    uv_t   dd8_reg  [NLANE];
    side_t side8_reg;

    num_t  mag [NLANE];
    logic [NLANE-1:0][NW-1:0] numer_next;
    logic [NLANE-1:0][DW-1:0] denom_next;
    logic [NLANE-1:0]         neg_next;

    logic [NLANE-1:0][NW-1:0] numer_reg;
    logic [NLANE-1:0][DW-1:0] denom_reg;
    logic [NLANE-1:0]         neg_reg;
    side_t                    side9_reg;

    // valid bits follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (enable)
        begin
            v_reg <= {v_reg[7:0], query_valid};
        end
    end

    always_comb
    begin
        q_in[0]    = query.query_x;
        q_in[1]    = query.query_y;
        q_in[2]    = query.query_z;
        p_in[0][0] = query.corner_a_x;
        p_in[0][1] = query.corner_a_y;
        p_in[0][2] = query.corner_a_z;
        p_in[1][0] = query.corner_b_x;
        p_in[1][1] = query.corner_b_y;
        p_in[1][2] = query.corner_b_z;
        p_in[2][0] = query.corner_c_x;
        p_in[2][1] = query.corner_c_y;
        p_in[2][2] = query.corner_c_z;
    end

    // stage 1: edge vectors and query offsets
    // stage 2: dot products
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            q1_reg    <= q_in;
            p1_reg    <= p_in;
            e1_reg[0] <= sub3(p_in[1], p_in[0]);
            e1_reg[1] <= sub3(p_in[2], p_in[1]);
            e1_reg[2] <= sub3(p_in[0], p_in[2]);
            for (int i = 0; i < 3; i++)
            begin
                w1_reg[i] <= sub3(q_in, p_in[i]);
            end

            q2_reg <= q1_reg;
            p2_reg <= p1_reg;
            e2_reg <= e1_reg;
            for (int i = 0; i < 3; i++)
            begin
                tf2_reg[i] <= dot3(e1_reg[i], w1_reg[i]);
                td2_reg[i] <= dot3(e1_reg[i], e1_reg[i]);
            end
            x01_reg <= dot3(e1_reg[2], e1_reg[0]);
            x02_reg <= dot3(e1_reg[2], w1_reg[0]);
        end
    end

    // face terms: v0 = C-A = -e2, v1 = B-A = e0, v2 = Q-A = w0
    always_comb
    begin
        d00 = td2_reg[2];
        d11 = td2_reg[0];
        d12 = tf2_reg[0];
        d01 = -x01_reg;
        d02 = -x02_reg;
    end

    // stage 3: limb products of dot products
    // stage 4: limb sums
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            q3_reg  <= q2_reg;
            p3_reg  <= p2_reg;
            e3_reg  <= e2_reg;
            tf3_reg <= tf2_reg;
            td3_reg <= td2_reg;
            pa_reg  <= mulp_parts(d00, d11);
            pb_reg  <= mulp_parts(d01, d01);
            pc_reg  <= mulp_parts(d11, d02);
            pd_reg  <= mulp_parts(d01, d12);
            pe_reg  <= mulp_parts(d00, d12);
            pf_reg  <= mulp_parts(d01, d02);

            q4_reg  <= q3_reg;
            p4_reg  <= p3_reg;
            e4_reg  <= e3_reg;
            tf4_reg <= tf3_reg;
            td4_reg <= td3_reg;
            ma_reg  <= mulp_sum(pa_reg);
            mb_reg  <= mulp_sum(pb_reg);
            mc_reg  <= mulp_sum(pc_reg);
            md_reg  <= mulp_sum(pd_reg);
            me_reg  <= mulp_sum(pe_reg);
            mf_reg  <= mulp_sum(pf_reg);
        end
    end

    // barycentric test and edge clamp decisions
    always_comb
    begin
        den    = ma_reg - mb_reg;
        u_val  = uv_t'(mc_reg) - uv_t'(md_reg);
        v_val  = uv_t'(me_reg) - uv_t'(mf_reg);
        uv_sum = (UW+1)'(u_val) + (UW+1)'(v_val);
        den_x  = (UW+1)'(den);
        degen  = (den == '0);
        face   = (den > 0) && (u_val > 0) && (v_val > 0) && (uv_sum < den_x);
        for (int i = 0; i < 3; i++)
        begin
            if (face && i == 0)
            begin
                pick[i] = PICK_INTERP;
            end
            else if ((tf4_reg[i] < 0) || (td4_reg[i] == '0))
            begin
                pick[i] = PICK_START;
            end
            else if (tf4_reg[i] > td4_reg[i])
            begin
                pick[i] = PICK_END;
            end
            else
            begin
                pick[i] = PICK_INTERP;
            end
        end
        side_next.q     = q4_reg;
        side_next.p     = p4_reg;
        side_next.face  = face;
        side_next.degen = degen;
        side_next.pick  = pick;
    end

    // stage 5
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            e5_reg    <= e4_reg;
            tf5_reg   <= tf4_reg;
            td5_reg   <= td4_reg;
            den5_reg  <= den;
            u5_reg    <= u_val;
            v5_reg    <= v_val;
            side5_reg <= side_next;
        end
    end

    // stage 6: limb products of the lane numerators
    // stage 7: limb sums
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int k = 0; k < 3; k++)
            begin
                fu6_reg[k] <= mulw_parts(u5_reg, -$signed(e5_reg[2][k]));
                fv6_reg[k] <= mulw_parts(v5_reg, $signed(e5_reg[0][k]));
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ep6_reg[3*i+k] <= mult_parts(tf5_reg[i], $signed(e5_reg[i][k]));
                end
            end
            td6_reg   <= td5_reg;
            den6_reg  <= den5_reg;
            side6_reg <= side5_reg;

            for (int k = 0; k < 3; k++)
            begin
                fu7_reg[k] <= mulw_sum(fu6_reg[k]);
                fv7_reg[k] <= mulw_sum(fv6_reg[k]);
            end
            for (int l = 0; l < NLANE; l++)
            begin
                en7_reg[l] <= mult_sum(ep6_reg[l]);
            end
            td7_reg   <= td6_reg;
            den7_reg  <= den6_reg;
            side7_reg <= side6_reg;
        end
    end

    // numerators per divider lane; face mode borrows the first edge's lanes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (side7_reg.face && i == 0)
                begin
                    lnum[3*i+k] = fu7_reg[k] + fv7_reg[k];
                    lden[3*i+k] = uv_t'(den7_reg);
                end
                else
                begin
                    lnum[3*i+k] = en7_reg[3*i+k];
                    lden[3*i+k] = uv_t'(td7_reg[i]);
                end
            end
        end
    end

    // stage 8
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            num8_reg  <= lnum;
            dd8_reg   <= lden;
            side8_reg <= side7_reg;
        end
    end

    // round-to-nearest setup: (2|n| + d) / (2d)
    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            neg_next[l]   = num8_reg[l][FNW-1];
            mag[l]        = neg_next[l] ? -num8_reg[l] : num8_reg[l];
            numer_next[l] = (NW'($unsigned(mag[l])) << 1) + NW'($unsigned(dd8_reg[l]));
            denom_next[l] = {dd8_reg[l][DW-2:0], 1'b0};
        end
    end

    // stage 9
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            numer_reg <= numer_next;
            denom_reg <= denom_next;
            neg_reg   <= neg_next;
            side9_reg <= side8_reg;
        end
    end

    assign lane_valid = v_reg[8];
    assign side       = side9_reg;
    assign numer      = numer_reg;
    assign denom      = denom_reg;
    assign negative   = neg_reg;

endmodule

>>> rtl/ptc_div.sv
module ptc_div import ptc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic                          start_valid,
    input  side_t                         start_side,
    input  logic [NLANE-1:0][NW-1:0]      numer,
    input  logic [NLANE-1:0][DW-1:0]      denom,
    input  logic [NLANE-1:0]              negative,
    output logic                          done_valid,
    output side_t                         done_side,
    output logic [NLANE-1:0][QW:0]        quot
);

    // one quotient bit per stage, MSB first, all lanes in lockstep
    logic [QW-1:0] vld_reg;
    side_t         side_reg [QW];

    logic [NW-1:0] rem_reg  [QW][NLANE];
    logic [NW-1:0] rem_next [QW][NLANE];
    logic [DW-1:0] dvs_reg  [QW][NLANE];
    logic [DW-1:0] dvs_next [QW][NLANE];
    logic [QW-1:0] quo_reg  [QW][NLANE];
    logic [QW-1:0] quo_next [QW][NLANE];
    logic          neg_reg  [QW][NLANE];
    logic          neg_next [QW][NLANE];

    logic [NW-1:0] r_src;
    logic [DW-1:0] d_src;
    logic [QW-1:0] q_src;
    logic          n_src;
    logic [NW-1:0] trial;

    always_comb
    begin
        for (int s = 0; s < QW; s++)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                if (s == 0)
                begin
                    r_src = numer[l];
                    d_src = denom[l];
                    q_src = '0;
                    n_src = negative[l];
                end
                else
                begin
                    r_src = rem_reg[s-1][l];
                    d_src = dvs_reg[s-1][l];
                    q_src = quo_reg[s-1][l];
                    n_src = neg_reg[s-1][l];
                end
                trial = NW'(d_src) << (QW - 1 - s);
                if (r_src >= trial)
                begin
                    rem_next[s][l] = r_src - trial;
                    quo_next[s][l] = q_src | (QW'(1) << (QW - 1 - s));
                end
                else
                begin
                    rem_next[s][l] = r_src;
                    quo_next[s][l] = q_src;
                end
                dvs_next[s][l] = d_src;
                neg_next[s][l] = n_src;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (enable)
        begin
            vld_reg <= {vld_reg[QW-2:0], start_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            rem_reg     <= rem_next;
            dvs_reg     <= dvs_next;
            quo_reg     <= quo_next;
            neg_reg     <= neg_next;
            side_reg[0] <= start_side;
            for (int s = 1; s < QW; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // restore the sign
    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            quot[l] = neg_reg[QW-1][l] ? -((QW+1)'(quo_reg[QW-1][l]))
                                       : (QW+1)'(quo_reg[QW-1][l]);
        end
    end

    assign done_valid = vld_reg[QW-1];
    assign done_side  = side_reg[QW-1];

endmodule

>>> rtl/ptc_sel.sv
module ptc_sel import ptc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic                          done_valid,
    input  side_t                         done_side,
    input  logic [NLANE-1:0][QW:0]        quot,
    output logic                          hit_valid,
    output hit_t                          hit,
    output logic [D2W-1:0]                hit_dist2
);

    logic [2:0] v_reg;

    cand_t cand_next [3][3];
    cand_t cand1_reg [3][3];
    cand_t cand2_reg [3][3];
    cvec_t q1_reg;
    logic  face1_reg, degen1_reg, face2_reg, degen2_reg;

    logic signed [PW:0] diff;
    dist2_t dsq;
    dist2_t d2_next [3];
    dist2_t d2_reg  [3];

    logic [1:0] idx;
    hit_t       hit_next;
    hit_t       hit_reg;
    dist2_t     best_next;
    dist2_t     best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (enable)
        begin
            v_reg <= {v_reg[1:0], done_valid};
        end
    end

    // edge candidates: start, end, or start plus rounded quotient
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case (done_side.pick[i])
                    PICK_START:
                        cand_next[i][k] = PW'($signed(done_side.p[i][k]));
                    PICK_END:
                        cand_next[i][k] = PW'($signed(done_side.p[(i == 2) ? 0 : i + 1][k]));
                    PICK_INTERP:
                        cand_next[i][k] = PW'($signed(done_side.p[i][k]))
                                        + PW'($signed(quot[3*i+k]));
                    default:
                        cand_next[i][k] = PW'($signed(done_side.p[i][k]));
                endcase
            end
        end
    end

    // squared distance per candidate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dsq = '0;
            for (int k = 0; k < 3; k++)
            begin
                diff = (PW+1)'($signed(q1_reg[k])) - (PW+1)'(cand1_reg[i][k]);
                dsq  = dsq + D2W'(diff) * D2W'(diff);
            end
            d2_next[i] = dsq;
        end
    end

    // nearest candidate, earlier wins ties; face result sits in slot 0
    always_comb
    begin
        idx = 2'd0;
        if (!face2_reg)
        begin
            if (d2_reg[1] < d2_reg[0])
            begin
                idx = 2'd1;
            end
            if (d2_reg[2] < d2_reg[idx])
            begin
                idx = 2'd2;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            hit_next.pt[k] = cand2_reg[idx][k][CW-1:0];
        end
        hit_next.face  = face2_reg;
        hit_next.degen = degen2_reg;
        best_next      = d2_reg[idx];
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            cand1_reg  <= cand_next;
            q1_reg     <= done_side.q;
            face1_reg  <= done_side.face;
            degen1_reg <= done_side.degen;

            cand2_reg  <= cand1_reg;
            d2_reg     <= d2_next;
            face2_reg  <= face1_reg;
            degen2_reg <= degen1_reg;

            hit_reg    <= hit_next;
            best_reg   <= best_next;
        end
    end

    assign hit_valid = v_reg[2];
    assign hit       = hit_reg;
    assign hit_dist2 = best_reg;

endmodule

>>> rtl/ptc_sqrt.sv
module ptc_sqrt import ptc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           enable,
    input  logic           hit_valid,
    input  hit_t           hit,
    input  logic [D2W-1:0] hit_dist2,
    output logic           result_valid,
    output result_t        result
);

    localparam logic [RW-1:0] DIST_MAX = RW'({(CW+1){1'b1}});

    // one root bit per stage, then a rounding stage that is the output register
    logic [QW-1:0]  vld_reg;
    hit_t           hit_reg  [QW];
    logic [D2W-1:0] rem_reg  [QW];
    logic [D2W-1:0] rem_next [QW];
    logic [RW-1:0]  root_reg  [QW];
    logic [RW-1:0]  root_next [QW];

    logic [D2W-1:0] r_src;
    logic [RW-1:0]  t_src;
    logic [D2W-1:0] trial;

    logic [RW-1:0]  rounded;
    result_t        res_next;
    result_t        res_reg;
    logic           out_vld_reg;

    // remainder x - r^2; trying bit b costs (r << (b+1)) + 4^b
    always_comb
    begin
        for (int s = 0; s < QW; s++)
        begin
            if (s == 0)
            begin
                r_src = hit_dist2;
                t_src = '0;
            end
            else
            begin
                r_src = rem_reg[s-1];
                t_src = root_reg[s-1];
            end
            trial = (D2W'(t_src) << (QW - s)) + (D2W'(1) << (2 * (QW - 1 - s)));
            if (r_src >= trial)
            begin
                rem_next[s]  = r_src - trial;
                root_next[s] = t_src | (RW'(1) << (QW - 1 - s));
            end
            else
            begin
                rem_next[s]  = r_src;
                root_next[s] = t_src;
            end
        end
    end

    always_comb
    begin
        if (rem_reg[QW-1] > D2W'(root_reg[QW-1]))
        begin
            rounded = root_reg[QW-1] + RW'(1);
        end
        else
        begin
            rounded = root_reg[QW-1];
        end
        res_next.distance   = (rounded > DIST_MAX) ? DIST_MAX[CW:0] : rounded[CW:0];
        res_next.closest_x  = hit_reg[QW-1].pt[0];
        res_next.closest_y  = hit_reg[QW-1].pt[1];
        res_next.closest_z  = hit_reg[QW-1].pt[2];
        res_next.on_face    = hit_reg[QW-1].face;
        res_next.degenerate = hit_reg[QW-1].degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (enable)
        begin
            vld_reg     <= {vld_reg[QW-2:0], hit_valid};
            out_vld_reg <= vld_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            rem_reg    <= rem_next;
            root_reg   <= root_next;
            hit_reg[0] <= hit;
            for (int s = 1; s < QW; s++)
            begin
                hit_reg[s] <= hit_reg[s-1];
            end
            res_reg <= res_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = res_reg;

endmodule

>>> rtl/point_triangle_closest_point_top.sv
// Closest point on a triangle to a query point, with its distance, in signed
// Q16.16. Fully pipelined: one transaction is taken every clock while the
// pipeline is not held, and each result passes through 9 setup stages (in which
// each wide product is split into limb multiplies over two stages), 34 divider
// stages giving one quotient bit each, 3 candidate/select stages, 34 square-root
// stages and one rounding stage that is the output register. The whole pipeline
// advances together and holds in place while a finished result waits on
// result_ready, so query_ready drops only in that case. The divider lanes, one
// per edge and axis, serve the edge projections; when the projection lands
// strictly inside the triangle the first three lanes carry the face projection
// instead. Degenerate triangles fall back to the edge search and flag it.
module point_triangle_closest_point_top import ptc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    query_valid,
    output logic    query_ready,
    input  query_t  query,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic                     enable;
    logic                     lane_valid;
    side_t                    lane_side;
    logic [NLANE-1:0][NW-1:0] numer;
    logic [NLANE-1:0][DW-1:0] denom;
    logic [NLANE-1:0]         negative;
    logic                     done_valid;
    side_t                    done_side;
    logic [NLANE-1:0][QW:0]   quot;
    logic                     hit_valid;
    hit_t                     hit;
    logic [D2W-1:0]           hit_dist2;

    // global advance: move whenever the output slot is free or being taken
    assign enable      = !result_valid || result_ready;
    assign query_ready = enable;

    ptc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (enable),
        .query_valid (query_valid),
        .query       (query),
        .lane_valid  (lane_valid),
        .side        (lane_side),
        .numer       (numer),
        .denom       (denom),
        .negative    (negative)
    );

    ptc_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (enable),
        .start_valid (lane_valid),
        .start_side  (lane_side),
        .numer       (numer),
        .denom       (denom),
        .negative    (negative),
        .done_valid  (done_valid),
        .done_side   (done_side),
        .quot        (quot)
    );

    ptc_sel u_sel (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (enable),
        .done_valid (done_valid),
        .done_side  (done_side),
        .quot       (quot),
        .hit_valid  (hit_valid),
        .hit        (hit),
        .hit_dist2  (hit_dist2)
    );

    ptc_sqrt u_sqrt (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable       (enable),
        .hit_valid    (hit_valid),
        .hit          (hit),
        .hit_dist2    (hit_dist2),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
